// ===== hw/rtl/sdt_pkg.sv =====
// Shared types, register codes and constants for the stereo triangulation core.
// No dependencies.
package sdt_pkg;

    localparam int DEF_MAX_COLUMNS = 4096;
    localparam int DEF_MAX_ROWS    = 4096;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_HEIGHT = 3'd5;

    localparam logic [31:0] RST_FOCAL_X      = 32'd32768000;
    localparam logic [31:0] RST_FOCAL_Y      = 32'd32768000;
    localparam logic [31:0] RST_CENTER_X     = 32'd20971520;
    localparam logic [31:0] RST_CENTER_Y     = 32'd15728640;
    localparam logic [30:0] RST_BASELINE     = 31'd6554;
    localparam logic [31:0] RST_FLOOR_HEIGHT = 32'd10158;

    localparam logic [19:0] ZMIN_Q = 20'd54395;
    localparam logic [19:0] ZMAX_Q = 20'd655360;

    // divider steps per pipeline stage
    localparam int DIV_STEPS = 2;
    localparam int Z_BITS    = 20;
    localparam int P_BITS    = 32;
    localparam int Z_STAGES  = Z_BITS / DIV_STEPS;
    localparam int P_STAGES  = P_BITS / DIV_STEPS;
    localparam int LATENCY   = Z_STAGES + P_STAGES + 5;

    typedef struct packed {
        logic [11:0]        column;
        logic [11:0]        row;
        logic signed [15:0] disparity;
    } t_pix_in;

    typedef struct packed {
        logic               point_valid;
        logic [19:0]        depth_z;
        logic signed [31:0] side_x;
        logic signed [31:0] up_y;
    } t_point_out;

    typedef struct packed {
        logic        ok;
        logic [14:0] disp;
        logic        neg_x;
        logic        neg_y;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [19:0] z;
        logic        ovf_x;
        logic        ovf_y;
    } t_ctx;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

// ===== hw/rtl/stereo_disparity_triangulation_core.sv =====
// Throughput: one pixel per cycle, o_busy stays low; results cannot be stalled.
// Depth divider: 10 stages of 2 restoring steps; X/Y dividers: 16 stages of 2 steps.
// Synchronous active-low reset clears the valid pipe and loads register defaults.
// Depends on sdt_pkg.
module stereo_disparity_triangulation_core
    import sdt_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_pix_in              i_data,
    output logic                 o_strobe,
    output t_point_out           o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

    logic [31:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    logic [30:0] r_baseline;
    logic signed [31:0] r_floor_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x      <= RST_FOCAL_X;
            r_focal_y      <= RST_FOCAL_Y;
            r_center_x     <= RST_CENTER_X;
            r_center_y     <= RST_CENTER_Y;
            r_baseline     <= RST_BASELINE;
            r_floor_height <= RST_FLOOR_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FOCAL_X:      r_focal_x      <= i_cfg_data;
                CFG_FOCAL_Y:      r_focal_y      <= i_cfg_data;
                CFG_CENTER_X:     r_center_x     <= i_cfg_data;
                CFG_CENTER_Y:     r_center_y     <= i_cfg_data;
                CFG_BASELINE:     r_baseline     <= i_cfg_data[30:0];
                CFG_FLOOR_HEIGHT: r_floor_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // stage A: capture pixel, partial products of baseline * focal_x
    logic        r_av;
    logic [11:0] r_a_u, r_a_v;
    logic [14:0] r_a_d;
    logic        r_a_ok;
    logic [46:0] r_a_lo, r_a_hi;
    logic        n_a_ok;

    always_comb begin
        n_a_ok = ({20'd0, i_data.column} < 32'(MAX_COLUMNS))
              && ({20'd0, i_data.row} < 32'(MAX_ROWS))
              && (i_data.disparity > 16'sd0)
              && (r_focal_y != 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else begin
            r_av <= i_start && !o_busy;
        end
        r_a_u  <= i_data.column;
        r_a_v  <= i_data.row;
        r_a_d  <= i_data.disparity[14:0];
        r_a_ok <= n_a_ok;
        r_a_lo <= 47'(r_baseline) * 47'(r_focal_x[15:0]);
        r_a_hi <= 47'(r_baseline) * 47'(r_focal_x[31:16]);
    end

    // stage B (index 0 of depth divider arrays): sum, overflow check, pixel offsets
    logic        r_zv [0:Z_STAGES];
    logic [14:0] r_zr [0:Z_STAGES];
    logic [19:0] r_zl [0:Z_STAGES];
    t_ctx        r_zc [0:Z_STAGES];
    logic [14:0] n_zr [1:Z_STAGES];
    logic [19:0] n_zl [1:Z_STAGES];

    logic [62:0] n_num;
    logic signed [33:0] n_dx, n_dy;
    t_ctx        n_bc;

    always_comb begin
        n_num = {16'd0, r_a_lo} + {r_a_hi, 16'd0};
        n_dx  = $signed({6'd0, r_a_u, 16'd0}) - $signed({2'd0, r_center_x});
        n_dy  = $signed({6'd0, r_a_v, 16'd0}) - $signed({2'd0, r_center_y});
        n_bc       = '0;
        // quotient of 2^20 or more is far beyond the depth gate
        n_bc.ok    = r_a_ok && (n_num[62:32] < {16'd0, r_a_d});
        n_bc.disp  = r_a_d;
        n_bc.neg_x = n_dx[33];
        n_bc.neg_y = n_dy[33];
        n_bc.mag_x = n_dx[33] ? 32'(-n_dx) : n_dx[31:0];
        n_bc.mag_y = n_dy[33] ? 32'(-n_dy) : n_dy[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zv[0] <= 1'b0;
        end else begin
            r_zv[0] <= r_av;
        end
        r_zr[0] <= n_num[46:32];
        r_zl[0] <= n_num[31:12];
        r_zc[0] <= n_bc;
    end

    // depth divider: restoring, quotient bits shift into the low word
    always_comb begin
        logic [14:0] rem;
        logic [19:0] low;
        logic [15:0] t;
        for (int j = 1; j <= Z_STAGES; j++) begin
            rem = r_zr[j-1];
            low = r_zl[j-1];
            for (int k = 0; k < DIV_STEPS; k++) begin
                t   = {rem, low[19]};
                low = {low[18:0], 1'b0};
                if (t >= {1'b0, r_zc[j-1].disp}) begin
                    rem    = 15'(t - {1'b0, r_zc[j-1].disp});
                    low[0] = 1'b1;
                end else begin
                    rem = t[14:0];
                end
            end
            n_zr[j] = rem;
            n_zl[j] = low;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 1; j <= Z_STAGES; j++) begin
            if (!i_rst_n) begin
                r_zv[j] <= 1'b0;
            end else begin
                r_zv[j] <= r_zv[j-1];
            end
            r_zr[j] <= n_zr[j];
            r_zl[j] <= n_zl[j];
            r_zc[j] <= r_zc[j-1];
        end
    end

    // stage C: depth gate, offset * depth
    logic        r_cv;
    t_ctx        r_c_ctx;
    logic [51:0] r_c_px, r_c_py;
    t_ctx        n_cc;

    always_comb begin
        n_cc    = r_zc[Z_STAGES];
        n_cc.z  = r_zl[Z_STAGES];
        n_cc.ok = n_cc.ok && (n_cc.z >= ZMIN_Q) && (n_cc.z <= ZMAX_Q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= r_zv[Z_STAGES];
        end
        r_c_ctx <= n_cc;
        r_c_px  <= 52'(n_cc.mag_x) * 52'(n_cc.z);
        r_c_py  <= 52'(n_cc.mag_y) * 52'(n_cc.z);
    end

    // stage D (index 0 of projection arrays) and projection dividers
    logic        r_pv  [0:P_STAGES];
    logic [31:0] r_pxr [0:P_STAGES];
    logic [31:0] r_pxl [0:P_STAGES];
    logic [31:0] r_pyr [0:P_STAGES];
    logic [31:0] r_pyl [0:P_STAGES];
    t_ctx        r_pc  [0:P_STAGES];
    logic [31:0] n_pxr [1:P_STAGES];
    logic [31:0] n_pxl [1:P_STAGES];
    logic [31:0] n_pyr [1:P_STAGES];
    logic [31:0] n_pyl [1:P_STAGES];
    t_ctx        n_dc;

    always_comb begin
        n_dc       = r_c_ctx;
        n_dc.ovf_x = {12'd0, r_c_px[51:32]} >= r_focal_x;
        n_dc.ovf_y = {12'd0, r_c_py[51:32]} >= r_focal_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv[0] <= 1'b0;
        end else begin
            r_pv[0] <= r_cv;
        end
        r_pxr[0] <= {12'd0, r_c_px[51:32]};
        r_pxl[0] <= r_c_px[31:0];
        r_pyr[0] <= {12'd0, r_c_py[51:32]};
        r_pyl[0] <= r_c_py[31:0];
        r_pc[0]  <= n_dc;
    end

    always_comb begin
        logic [31:0] rx, lx, ry, ly;
        logic [32:0] tx, ty;
        for (int j = 1; j <= P_STAGES; j++) begin
            rx = r_pxr[j-1];
            lx = r_pxl[j-1];
            ry = r_pyr[j-1];
            ly = r_pyl[j-1];
            for (int k = 0; k < DIV_STEPS; k++) begin
                tx = {rx, lx[31]};
                lx = {lx[30:0], 1'b0};
                if (tx >= {1'b0, r_focal_x}) begin
                    rx    = 32'(tx - {1'b0, r_focal_x});
                    lx[0] = 1'b1;
                end else begin
                    rx = tx[31:0];
                end
                ty = {ry, ly[31]};
                ly = {ly[30:0], 1'b0};
                if (ty >= {1'b0, r_focal_y}) begin
                    ry    = 32'(ty - {1'b0, r_focal_y});
                    ly[0] = 1'b1;
                end else begin
                    ry = ty[31:0];
                end
            end
            n_pxr[j] = rx;
            n_pxl[j] = lx;
            n_pyr[j] = ry;
            n_pyl[j] = ly;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 1; j <= P_STAGES; j++) begin
            if (!i_rst_n) begin
                r_pv[j] <= 1'b0;
            end else begin
                r_pv[j] <= r_pv[j-1];
            end
            r_pxr[j] <= n_pxr[j];
            r_pxl[j] <= n_pxl[j];
            r_pyr[j] <= n_pyr[j];
            r_pyl[j] <= n_pyl[j];
            r_pc[j]  <= r_pc[j-1];
        end
    end

    // stage E: sign, floor gate, saturation
    t_ctx               n_ec;
    logic [32:0]        n_qx, n_qy;
    logic signed [33:0] n_sx, n_sy, n_fh;
    logic               n_valid;
    t_point_out         n_res;
    logic               r_o_strobe;
    t_point_out         r_o_res;

    always_comb begin
        n_ec = r_pc[P_STAGES];
        // an overflowed quotient only needs to land beyond the 32-bit range
        n_qx = n_ec.ovf_x ? 33'h1_0000_0000 : {1'b0, r_pxl[P_STAGES]};
        n_qy = n_ec.ovf_y ? 33'h1_0000_0000 : {1'b0, r_pyl[P_STAGES]};
        n_sx = n_ec.neg_x ? -$signed({1'b0, n_qx}) : $signed({1'b0, n_qx});
        n_sy = n_ec.neg_y ? -$signed({1'b0, n_qy}) : $signed({1'b0, n_qy});
        n_fh = {{2{r_floor_height[31]}}, r_floor_height};
        n_valid = n_ec.ok && !(n_sy > n_fh);
        n_res = '0;
        if (n_valid) begin
            n_res.point_valid = 1'b1;
            n_res.depth_z     = n_ec.z;
            n_res.side_x      = sat32(n_sx);
            n_res.up_y        = sat32(n_sy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= r_pv[P_STAGES];
        end
        r_o_res <= n_res;
    end

    assign o_strobe = r_o_strobe;
    assign o_result = r_o_res;

endmodule

// ===== hw/rtl/sdt_checker.sv =====
// Port-level checks for the stereo triangulation core, bound to the top level.
// Depends on sdt_pkg.
module sdt_checker
    import sdt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_strobe,
    input t_point_out o_result
);

    logic [5:0] r_warm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= 6'd0;
        end else if (r_warm != 6'(LATENCY)) begin
            r_warm <= r_warm + 6'd1;
        end
    end

    // each result transfer matches a start transfer a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_warm == 6'(LATENCY)) |-> (o_strobe == $past(i_start && !o_busy, LATENCY)))
        else $error("result strobe does not match start history");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.point_valid) |->
            (o_result.depth_z == 20'd0 && o_result.side_x == 32'sd0
             && o_result.up_y == 32'sd0))
        else $error("invalid point carries non-zero coordinates");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.point_valid) |->
            (o_result.depth_z >= ZMIN_Q && o_result.depth_z <= ZMAX_Q))
        else $error("valid point with depth outside gate");

    a_no_strobe_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_warm == 6'd0) |-> !o_strobe)
        else $error("strobe straight after reset");

endmodule

bind stereo_disparity_triangulation_core sdt_checker u_sdt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
